### rtl/pag_pkg.sv
// Shared types, constants and elaboration-time helpers for the pixel accumulator.
package pag_pkg;

  // Store geometry and sum width.
  localparam int MaxPixels = 65536;
  localparam int AddrW     = 16;
  localparam int SumW      = 32;
  localparam int CountW    = 16;

  // Gamma table: one entry per Q.12 level from 0.0 to 1.0 inclusive.
  localparam int LutDepth  = 4097;
  localparam int LutAw     = 13;
  localparam int QuotOne   = 4096;
  localparam int DivSteps  = 13;

  // Widths of the forward-difference registers used to build the table.
  localparam int DaW = 96;
  localparam int DbW = 150;

  // Opcodes.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

  // Input word.
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic        [15:0] in_red;
    logic        [15:0] in_green;
    logic        [15:0] in_blue;
  } pag_in_t;

  // Output word.
  typedef struct packed {
    logic [15:0] pixel_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
  } pag_out_t;

  // Divider control and status between the top level and a divider lane.
  typedef struct packed {
    logic start;
    logic busy;
  } pag_div_ctl_t;

  // k-th forward difference of scale * x^e taken at x0; elaboration only.
  function automatic logic [159:0] pag_fdiff(input int k, input int x0, input int e,
                                             input logic [159:0] scale);
    logic [159:0] vals [12];
    logic [159:0] p;
    for (int j = 0; j < 12; j++) begin
      p = scale;
      for (int m = 0; m < e; m++) begin
        p = p * 160'(x0 + j);
      end
      vals[j] = p;
    end
    for (int l = 0; l < k; l++) begin
      for (int j = 0; j < 11; j++) begin
        vals[j] = vals[j+1] - vals[j];
      end
    end
    return vals[0];
  endfunction

endpackage

### rtl/pag_div.sv
// Bit-serial restoring divider that yields a quotient clamped to 1.0 in Q.12.
module pag_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pag_pkg::SumW-1:0]   dividend_i,
  input  logic [pag_pkg::CountW-1:0] divisor_i,
  output logic                       busy_o,
  output logic [pag_pkg::LutAw-1:0]  quot_o
);
  import pag_pkg::*;

  logic [3:0]        cnt_q;
  logic              busy_q;
  logic              sat_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] divisor_q;
  logic [LutAw-1:0]  sh_q;
  logic [LutAw-1:0]  quo_q;

  logic [CountW:0]   trial;
  logic              ge;
  logic              sat_start;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial     = {rem_q, sh_q[LutAw-1]};
  assign ge        = trial >= {1'b0, divisor_q};
  assign sat_start = dividend_i >= {3'b000, divisor_i, {LutAw{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q    <= 1'b1;
      cnt_q     <= 4'(DivSteps - 1);
      sat_q     <= sat_start;
      divisor_q <= divisor_i;
      rem_q     <= sat_start ? '0 : dividend_i[SumW-4:LutAw];
      sh_q      <= dividend_i[LutAw-1:0];
      quo_q     <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? CountW'(trial - {1'b0, divisor_q}) : trial[CountW-1:0];
      sh_q  <= {sh_q[LutAw-2:0], 1'b0};
      quo_q <= {quo_q[LutAw-2:0], ge};
      cnt_q <= cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Quotients above 1.0 read as 1.0.
  assign busy_o = busy_q;
  assign quot_o = (sat_q || quo_q > LutAw'(QuotOne)) ? LutAw'(QuotOne) : quo_q;

endmodule

### rtl/pag_gamma.sv
// Gamma table: built after reset by exact forward differences, then read as a memory.
module pag_gamma (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pag_pkg::LutAw-1:0] rd_addr_i,
  output logic [7:0]                rd_data_o,
  output logic                      ready_o
);
  import pag_pkg::*;

  localparam logic [159:0] Scale255 = pag_fdiff(0, 255, 11, 160'd1);

  logic [7:0]       mem [LutDepth];
  logic [7:0]       rd_q;
  logic [LutAw-1:0] i_q;
  logic [7:0]       v_q;
  logic             done_q;
  // da_q tracks (v+1)^11, db_q tracks 255^11 * i^5.
  logic [DaW-1:0]   da_q [11];
  logic [DbW-1:0]   db_q [5];
  logic             fits;
  logic             wr_en;

  // Code v+1 fits when (v+1)^11 * 2^60 <= 255^11 * i^5.
  assign fits  = (v_q != 8'd255) && (da_q[0] <= {6'b0, db_q[0][DbW-1:60]});
  assign wr_en = !done_q && !fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      i_q    <= '0;
      v_q    <= '0;
      for (int k = 0; k < 11; k++) begin
        da_q[k] <= DaW'(pag_fdiff(k, 1, 11, 160'd1));
      end
      for (int k = 0; k < 5; k++) begin
        db_q[k] <= DbW'(pag_fdiff(k, 0, 5, Scale255));
      end
    end else if (!done_q) begin
      if (fits) begin
        v_q <= v_q + 8'd1;
        for (int k = 0; k < 10; k++) begin
          da_q[k] <= da_q[k] + da_q[k+1];
        end
        da_q[10] <= da_q[10] + DaW'(pag_fdiff(11, 1, 11, 160'd1));
      end else begin
        for (int k = 0; k < 4; k++) begin
          db_q[k] <= db_q[k] + db_q[k+1];
        end
        db_q[4] <= db_q[4] + DbW'(pag_fdiff(5, 0, 5, Scale255));
        if (i_q == LutAw'(LutDepth - 1)) begin
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  // Table storage with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[i_q] <= v_q;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign ready_o   = done_q;

endmodule

### rtl/pixel_accumulate_average_gamma.sv
// Top level of the progressive pixel accumulator with gamma-encoded averages.
// Usage:
//   Input words (in_valid_i/in_ready_o) carry an opcode, a pixel position and an
//   HDR color in Q4.12. An accumulate word adds the color to that pixel's
//   saturating 32-bit sums and returns one output word (out_valid_o/out_ready_i)
//   with the pixel index and the 8-bit gamma-encoded average; an out-of-frame
//   position returns nothing. A clear word zeroes the whole store.
//   Configuration words (cfg_valid_i/cfg_ready_o) set frame width, frame height
//   and sample count by index; cfg_ready_o is always high.
// Sequence:
//   An accumulate word passes from acceptance to the output register through
//   index, store read, add and write-back, three bit-serial dividers working
//   side by side (one quotient bit per cycle), gamma table reads through one
//   memory port, then the output load. The next word is taken in the cycle after
//   the output load. Out-of-frame words return to idle after the index step.
//   One word is processed at a time; a new word is taken while a result waits.
// Reset and stalls:
//   After reset the store is swept to zero, one pixel per cycle, across all 65536
//   pixels; the gamma table is built meanwhile. A clear word repeats that sweep.
//   A stalled receiver holds the result; the block then stops before its output.
module pixel_accumulate_average_gamma (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pag_pkg::pag_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pag_pkg::pag_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i
);
  import pag_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INDEX, S_READ, S_SUM, S_DIV, S_LUT, S_RES
  } state_e;

  state_e            state_q;
  pag_in_t           item_q;
  pag_out_t          out_q;
  logic              out_valid_q;
  logic [8:0]        width_q;
  logic [8:0]        height_q;
  logic [CountW-1:0] count_q;
  logic [AddrW-1:0]  clr_ptr_q;
  logic [AddrW-1:0]  idx_q;
  logic [1:0]        ch_q;
  logic [7:0]        red_q;
  logic [7:0]        green_q;
  logic [7:0]        blue_q;

  logic [3*SumW-1:0] store [MaxPixels];
  logic [3*SumW-1:0] rd_q;

  logic [17:0]       prod;
  logic [17:0]       idx_full;
  logic              in_ok;
  logic [CountW-1:0] div_count;
  logic [SumW:0]     raw_r, raw_g, raw_b;
  logic [SumW-1:0]   sum_r, sum_g, sum_b;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [3*SumW-1:0] mem_wdata;
  pag_div_ctl_t      div_r, div_g, div_b;
  logic [LutAw-1:0]  q_r, q_g, q_b;
  logic [LutAw-1:0]  lut_addr;
  logic [7:0]        lut_data;
  logic              lut_ready;

  // Bounds check and row-major index.
  assign prod     = {9'b0, item_q.pixel_y[8:0]} * {9'b0, width_q};
  assign idx_full = prod + {9'b0, item_q.pixel_x[8:0]};
  assign in_ok    = !item_q.pixel_x[15] && !item_q.pixel_y[15]
                    && (item_q.pixel_x[15:0] < {7'b0, width_q})
                    && (item_q.pixel_y[15:0] < {7'b0, height_q})
                    && (idx_full[17:16] == 2'b00);

  // Saturating channel sums.
  assign raw_r = {1'b0, rd_q[SumW-1:0]}        + {17'b0, item_q.in_red};
  assign raw_g = {1'b0, rd_q[2*SumW-1:SumW]}   + {17'b0, item_q.in_green};
  assign raw_b = {1'b0, rd_q[3*SumW-1:2*SumW]} + {17'b0, item_q.in_blue};
  assign sum_r = raw_r[SumW] ? '1 : raw_r[SumW-1:0];
  assign sum_g = raw_g[SumW] ? '1 : raw_g[SumW-1:0];
  assign sum_b = raw_b[SumW] ? '1 : raw_b[SumW-1:0];

  // A zero sample count divides as one.
  assign div_count = (count_q == '0) ? CountW'(1) : count_q;

  // Store port: clearing sweep or write-back of the new sums.
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_SUM);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_ptr_q : idx_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {sum_b, sum_g, sum_r};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_q <= store[idx_q];
  end

  // Three divider lanes started together.
  assign div_r.start = (state_q == S_SUM);
  assign div_g.start = (state_q == S_SUM);
  assign div_b.start = (state_q == S_SUM);

  pag_div u_div_r (
    .clk_i, .rst_ni, .start_i(div_r.start), .dividend_i(sum_r),
    .divisor_i(div_count), .busy_o(div_r.busy), .quot_o(q_r)
  );
  pag_div u_div_g (
    .clk_i, .rst_ni, .start_i(div_g.start), .dividend_i(sum_g),
    .divisor_i(div_count), .busy_o(div_g.busy), .quot_o(q_g)
  );
  pag_div u_div_b (
    .clk_i, .rst_ni, .start_i(div_b.start), .dividend_i(sum_b),
    .divisor_i(div_count), .busy_o(div_b.busy), .quot_o(q_b)
  );

  // One gamma read per cycle, channels in turn.
  always_comb begin
    case (ch_q)
      2'd0:    lut_addr = q_r;
      2'd1:    lut_addr = q_g;
      default: lut_addr = q_b;
    endcase
  end

  pag_gamma u_gamma (
    .clk_i, .rst_ni, .rd_addr_i(lut_addr), .rd_data_o(lut_data), .ready_o(lut_ready)
  );

  assign in_ready_o  = (state_q == S_IDLE) && lut_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control sequence, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_ptr_q   <= '0;
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      count_q     <= CountW'(1);
      out_valid_q <= 1'b0;
      ch_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[8:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i[8:0];
          CFG_SAMPLE_COUNT: count_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_ptr_q <= clr_ptr_q + 1'b1;
          if (clr_ptr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            item_q  <= in_data_i;
            state_q <= (in_data_i.opcode == OP_CLEAR) ? S_CLEAR : S_INDEX;
          end
        end
        S_INDEX: begin
          idx_q   <= idx_full[AddrW-1:0];
          state_q <= in_ok ? S_READ : S_IDLE;
        end
        S_READ: state_q <= S_SUM;
        S_SUM:  state_q <= S_DIV;
        S_DIV: begin
          ch_q <= '0;
          if (!div_r.busy) begin
            state_q <= S_LUT;
          end
        end
        S_LUT: begin
          ch_q <= ch_q + 2'd1;
          case (ch_q)
            2'd1:    red_q   <= lut_data;
            2'd2:    green_q <= lut_data;
            2'd3: begin
              blue_q  <= lut_data;
              state_q <= S_RES;
            end
            default: ;
          endcase
        end
        S_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.pixel_index <= idx_q;
            out_q.out_red     <= red_q;
            out_q.out_green   <= green_q;
            out_q.out_blue    <= blue_q;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The divider lanes always run in step.
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_r.busy == div_g.busy) && (div_g.busy == div_b.busy))
    else $error("divider lanes out of step");

  // No word is taken while the store is being swept.
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing sweep");

  // A clear word starts a sweep from pixel zero.
  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.opcode == OP_CLEAR)
    |=> (state_q == S_CLEAR) && (clr_ptr_q == '0))
    else $error("clear word did not start sweep at zero");

  // A result is only loaded when the output register is free or being drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");

endmodule
